### hdl/websocket_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define WSFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define WSFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define WSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wsfr_pkg.sv
// Package for the frame receiver: phase encoding, result kinds, protocol constants.
// Used by wsfr_parser, wsfr_out_stage, websocket_frame_receiver and the bench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsfr_pkg;

  localparam logic [3:0]  OPC_CLOSE    = 4'h8;
  localparam logic [6:0]  LEN_EXT16    = 7'h7E;
  localparam logic [6:0]  LEN_EXT64    = 7'h7F;
  localparam logic [15:0] CLOSE_STATUS = 16'd1000;
  localparam logic [7:0]  CLOSE_HDR    = {4'h8, OPC_CLOSE};
  localparam logic [7:0]  CLOSE_LEN    = 8'h02;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_EXT64 = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_EXTHI = 7'b0000100,
    PH_EXTLO = 7'b0001000,
    PH_MASK  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_STOP  = 7'b1000000
  } phase_t;

  // One step of the parser, as seen by the output stage.
  typedef struct packed {
    logic       vld;          // a payload, empty-frame or error result is present
    logic       start_reply;  // the close reply sequence begins
    logic [7:0] data;
    kind_t      kind;
    logic [3:0] opcode;
    logic       last;
  } step_res_t;

  // Bytes of the close reply, in wire order.
  function automatic logic [7:0] reply_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CLOSE_HDR;
      2'd1:    b = CLOSE_LEN;
      2'd2:    b = CLOSE_STATUS[15:8];
      default: b = CLOSE_STATUS[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/wsfr_parser.sv
// Frame header parser and payload unmasker: holds the per-frame state.
// Depends on wsfr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_receiver_macros.svh"

module wsfr_parser
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] byte_in,
  output step_res_t       res
);

  phase_t      phase_r,     phase_nxt;
  logic [3:0]  opcode_r,    opcode_nxt;
  logic        mask_flag_r, mask_flag_nxt;
  logic [15:0] len_r,       len_nxt;
  logic [15:0] left_r,      left_nxt;
  logic [31:0] key_r,       key_nxt;
  logic [1:0]  pos_r,       pos_nxt;

  logic [31:0] key_sh;
  logic [7:0]  key_byte;
  logic [15:0] left_dec;
  logic [15:0] hdr_len;
  logic        hdr_done;
  logic [1:0]  pos_inc;

  assign key_sh   = key_r << {pos_r, 3'b000};
  assign key_byte = mask_flag_r ? key_sh[31:24] : 8'h00;
  assign left_dec = left_r - 16'd1;
  assign pos_inc  = pos_r + 2'd1;

  always_comb begin
    phase_nxt     = phase_r;
    opcode_nxt    = opcode_r;
    mask_flag_nxt = mask_flag_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    hdr_done      = 1'b0;
    hdr_len       = len_r;
    res           = '0;
    res.opcode    = opcode_r;

    if (step_en) begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = byte_in[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_flag_nxt = byte_in[7];
          if (byte_in[6:0] == LEN_EXT64) begin
            res.vld   = 1'b1;
            res.kind  = KIND_EXT64;
            phase_nxt = PH_STOP;
          end else if (byte_in[6:0] == LEN_EXT16) begin
            phase_nxt = PH_EXTHI;
          end else begin
            len_nxt = {9'd0, byte_in[6:0]};
            hdr_len = len_nxt;
            if (byte_in[7]) begin
              phase_nxt = PH_MASK;
              pos_nxt   = 2'd0;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXTHI: begin
          len_nxt   = {byte_in, 8'h00};
          phase_nxt = PH_EXTLO;
        end
        PH_EXTLO: begin
          len_nxt = {len_r[15:8], byte_in};
          hdr_len = len_nxt;
          if (mask_flag_r) begin
            phase_nxt = PH_MASK;
            pos_nxt   = 2'd0;
          end else begin
            hdr_done = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], byte_in};
          pos_nxt = pos_inc;
          if (pos_inc == 2'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          pos_nxt  = pos_inc;
          left_nxt = left_dec;
          if (opcode_r == OPC_CLOSE) begin
            if (left_dec == 16'd0) begin
              res.start_reply = 1'b1;
              phase_nxt       = PH_STOP;
            end
          end else begin
            res.vld  = 1'b1;
            res.data = byte_in ^ key_byte;
            res.kind = KIND_DATA;
            res.last = (left_dec == 16'd0);
            if (left_dec == 16'd0) begin
              phase_nxt     = PH_HDR0;
              mask_flag_nxt = 1'b0;
              key_nxt       = '0;
              pos_nxt       = 2'd0;
            end
          end
        end
        PH_STOP: begin
          // Closed or stopped: every byte is dropped.
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase

      // Length and any mask key are in: start the payload or finish the frame.
      if (hdr_done) begin
        left_nxt = hdr_len;
        pos_nxt  = 2'd0;
        if (hdr_len != 16'd0) begin
          phase_nxt = PH_DATA;
        end else if (opcode_r == OPC_CLOSE) begin
          res.start_reply = 1'b1;
          phase_nxt       = PH_STOP;
        end else begin
          res.vld       = 1'b1;
          res.kind      = KIND_EMPTY;
          res.last      = 1'b1;
          phase_nxt     = PH_HDR0;
          mask_flag_nxt = 1'b0;
          key_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      opcode_r    <= '0;
      mask_flag_r <= 1'b0;
      len_r       <= '0;
      left_r      <= '0;
      key_r       <= '0;
      pos_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      opcode_r    <= opcode_nxt;
      mask_flag_r <= mask_flag_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      key_r       <= key_nxt;
      pos_r       <= pos_nxt;
    end
  end

  `WSFR_ASSERT_IMPL(a_data_has_bytes, phase_r == PH_DATA, left_r != 16'd0, "payload phase with no bytes left")
  `WSFR_ASSERT_ALWAYS(a_one_result_kind, !(res.vld && res.start_reply), "result and close reply in one step")
  `WSFR_ASSERT_NEXT(a_reply_stops, res.start_reply, phase_r == PH_STOP, "parser kept running after close")

endmodule

`default_nettype wire

### hdl/wsfr_out_stage.sv
// Result register and close reply sequencer of the frame receiver.
// Depends on wsfr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_receiver_macros.svh"

module wsfr_out_stage
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire step_res_t  res,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [3:0]      out_frame_opcode,
  output logic            out_last
);

  logic        valid_r,     valid_nxt;
  logic        reply_act_r, reply_act_nxt;
  logic [1:0]  reply_idx_r, reply_idx_nxt;
  logic [7:0]  byte_r,      byte_nxt;
  kind_t       kind_r,      kind_nxt;
  logic [3:0]  opc_r,       opc_nxt;
  logic        last_r,      last_nxt;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt     = valid_r && !out_ready;
    reply_act_nxt = reply_act_r;
    reply_idx_nxt = reply_idx_r;
    byte_nxt      = byte_r;
    kind_nxt      = kind_r;
    opc_nxt       = opc_r;
    last_nxt      = last_r;

    if (out_free) begin
      if (reply_act_r) begin
        valid_nxt     = 1'b1;
        byte_nxt      = reply_byte(reply_idx_r);
        kind_nxt      = KIND_CLOSE;
        opc_nxt       = OPC_CLOSE;
        last_nxt      = (reply_idx_r == 2'd3);
        reply_idx_nxt = reply_idx_r + 2'd1;
        reply_act_nxt = (reply_idx_r != 2'd3);
      end else if (res.start_reply) begin
        valid_nxt     = 1'b1;
        byte_nxt      = reply_byte(2'd0);
        kind_nxt      = KIND_CLOSE;
        opc_nxt       = OPC_CLOSE;
        last_nxt      = 1'b0;
        reply_idx_nxt = 2'd1;
        reply_act_nxt = 1'b1;
      end else if (res.vld) begin
        valid_nxt = 1'b1;
        byte_nxt  = res.data;
        kind_nxt  = res.kind;
        opc_nxt   = res.opcode;
        last_nxt  = res.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      reply_act_r <= 1'b0;
      reply_idx_r <= '0;
    end else begin
      valid_r     <= valid_nxt;
      reply_act_r <= reply_act_nxt;
      reply_idx_r <= reply_idx_nxt;
    end
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    opc_r  <= opc_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_kind         = kind_r;
  assign out_frame_opcode = opc_r;
  assign out_last         = last_r;

  `WSFR_ASSERT_ALWAYS(a_reply_exclusive, !(reply_act_r && (res.vld || res.start_reply)), "parser result during close reply")
  `WSFR_ASSERT_IMPL(a_reply_idx, reply_act_r, reply_idx_r != 2'd0, "close reply index lost")
  `WSFR_ASSERT_IMPL(a_reply_valid, reply_act_r, valid_r, "close reply running with empty result register")

endmodule

`default_nettype wire

### hdl/websocket_frame_receiver.sv
// A received byte is held in the input register and then in the result register before its
// result can transfer out.
// Throughput: one byte per cycle while the result register is free; the parser step stalls while it is full and unread.
// A close frame's reply fills the output register for four consecutive transfers.
// Reset (rst_n low, synchronous) returns the parser to the first header byte and empties both
// the input register and the result register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [3:0]      out_frame_opcode,
  output logic            out_last
);

  // The input register holds one received byte. It is handed to the parser
  // in the cycle the result register can take whatever that byte produces.
  // Because the parser creates at most one result per step (the close reply
  // is replayed by the output stage while the parser drops all input), one
  // free result slot is all a step needs.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_free;
  logic       step_en;
  step_res_t  res;

  assign step_en  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    // Payload register needs no reset; it is only read while valid.
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Header parsing, length and mask key capture, and payload unmasking.
  wsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .res     (res)
  );

  // Result register; also sequences the four bytes of the close reply.
  wsfr_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_frame_opcode (out_frame_opcode),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### bench/websocket_frame_receiver_tb.sv
// Self-checking bench for websocket_frame_receiver: random WebSocket frames in, unmasked bytes out.
// Depends on wsfr_pkg for the result kinds, the parser phases and the protocol constants.
`timescale 1ns / 1ps

module websocket_frame_receiver_tb;
  import wsfr_pkg::*;

  // The run limit leaves ample room for the slowest correct run, even with every
  // frame at its longest, every gap at its longest and the long receiver hold.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_TARGET = 380;
  // The receiver stops taking results for a long stretch once this many have arrived.
  localparam int unsigned LONG_HOLD_AT = 60;
  localparam int unsigned LONG_HOLD = 250;
  localparam int unsigned PRINT_CAP = 40;

  // Opening frames, sent first byte first:
  //   opcode 0 with the RSV bits set and FIN clear, one unmasked byte of 0xFF;
  //   text frame, masked, zero length in the 7-bit form;
  //   pong frame, unmasked, zero length in the 16-bit form;
  //   reserved opcode 0xF, masked, three bytes 0x00 0xFF 0x5A.
  localparam int OPENING_LEN = 22;
  localparam logic [OPENING_LEN*8-1:0] OPENING = {
    8'h70, 8'h01, 8'hFF,
    8'h81, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
    8'h8A, 8'h7E, 8'h00, 8'h00,
    8'h8F, 8'h83, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A
  };

  typedef struct {
    logic [7:0] b;
    logic       drain;  // hold this byte back until every expected result has arrived
  } rx_item_t;

  typedef struct {
    logic [7:0] b;
    kind_t      kind;
    logic [3:0] opc;
    logic       last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [3:0] out_frame_opcode;
  logic       out_last;

  websocket_frame_receiver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_frame_opcode (out_frame_opcode),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  // Bytes waiting to be sent, and results waiting to be seen, oldest first.
  rx_item_t      rx_stream[$];
  frame_result_t results_due[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  // Transfers seen at the last rising edge; the negedge drivers act on these.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  // Sender and receiver pacing. A "burst" flag turns idling off for a stretch.
  int unsigned snd_gap = 0;
  int unsigned rcv_gap = 0;
  logic        snd_burst = 1'b0;
  logic        rcv_burst = 1'b0;
  logic        long_hold_done = 1'b0;

  // Stimulus builder state: the next byte added carries the drain mark if set.
  logic hold_next = 1'b0;

  // ---------------------------------------------------------------------------
  // Parser prediction. Its state mirrors what the block must hold: the phase,
  // the opcode of the current frame, whether it is masked, its length, the bytes
  // still to come, the mask key and the position within the key.
  // ---------------------------------------------------------------------------
  phase_t      parse_phase = PH_HDR0;
  logic [3:0]  cur_opc = 4'h0;
  logic        masked = 1'b0;
  logic [15:0] frame_len = 16'h0000;
  logic [15:0] remaining = 16'h0000;
  logic [31:0] key = 32'h0;
  logic [1:0]  key_idx = 2'd0;

  task automatic queue_result(input logic [7:0] b, input kind_t kind, input logic [3:0] opc,
                              input logic last);
    frame_result_t r;
    r.b = b;
    r.kind = kind;
    r.opc = opc;
    r.last = last;
    results_due.push_back(r);
  endtask

  // The reply to a close frame: close header, length 2, status 1000 big-endian.
  // After it, the parser is done for good.
  task automatic queue_close_reply();
    queue_result(CLOSE_HDR, KIND_CLOSE, OPC_CLOSE, 1'b0);
    queue_result(CLOSE_LEN, KIND_CLOSE, OPC_CLOSE, 1'b0);
    queue_result(CLOSE_STATUS[15:8], KIND_CLOSE, OPC_CLOSE, 1'b0);
    queue_result(CLOSE_STATUS[7:0], KIND_CLOSE, OPC_CLOSE, 1'b1);
    parse_phase = PH_STOP;
  endtask

  task automatic rewind_frame();
    parse_phase = PH_HDR0;
    masked = 1'b0;
    key = 32'h0;
    key_idx = 2'd0;
  endtask

  // Header and any mask key are in. Zero-length frames finish right here.
  task automatic frame_header_done();
    remaining = frame_len;
    key_idx = 2'd0;
    if (remaining != 16'h0000) begin
      parse_phase = PH_DATA;
    end else if (cur_opc == OPC_CLOSE) begin
      queue_close_reply();
    end else begin
      queue_result(8'h00, KIND_EMPTY, cur_opc, 1'b1);
      rewind_frame();
    end
  endtask

  task automatic length_parsed();
    if (masked) begin
      parse_phase = PH_MASK;
      key_idx = 2'd0;
    end else begin
      frame_header_done();
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       fin;
    case (parse_phase)
      PH_HDR0: begin
        // FIN and RSV bits play no part; every frame stands on its own.
        cur_opc = b[3:0];
        parse_phase = PH_HDR1;
      end
      PH_HDR1: begin
        masked = b[7];
        if (b[6:0] == LEN_EXT64) begin
          // The 64-bit length form is not supported: one error marker, then the
          // parser ignores everything.
          queue_result(8'h00, KIND_EXT64, cur_opc, 1'b0);
          parse_phase = PH_STOP;
        end else if (b[6:0] == LEN_EXT16) begin
          parse_phase = PH_EXTHI;
        end else begin
          frame_len = {9'd0, b[6:0]};
          length_parsed();
        end
      end
      PH_EXTHI: begin
        frame_len = {b, 8'h00};
        parse_phase = PH_EXTLO;
      end
      PH_EXTLO: begin
        frame_len[7:0] = b;
        length_parsed();
      end
      PH_MASK: begin
        key = {key[23:0], b};
        key_idx = key_idx + 2'd1;
        if (key_idx == 2'd0) frame_header_done();
      end
      PH_DATA: begin
        kb = masked ? 8'(key >> (8 * (3 - key_idx))) : 8'h00;
        key_idx = key_idx + 2'd1;
        remaining = remaining - 16'd1;
        fin = (remaining == 16'h0000);
        // A close frame's payload is swallowed; only the reply comes out.
        if (cur_opc == OPC_CLOSE) begin
          if (fin) queue_close_reply();
        end else begin
          queue_result(b ^ kb, KIND_DATA, cur_opc, fin);
          if (fin) rewind_frame();
        end
      end
      default: ;  // stopped after a close reply or an unsupported length
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    rx_item_t it;
    it.b = b;
    it.drain = hold_next;
    hold_next = 1'b0;
    rx_stream.push_back(it);
  endtask

  // One complete frame with random FIN/RSV bits, random key and random payload.
  // Lengths above 125 always take the 16-bit form; "wide" forces it for short ones.
  task automatic add_frame(input logic [3:0] opc, input logic mk, input int unsigned len,
                           input logic wide);
    add_byte({4'($urandom), opc});
    if (wide || len > 125) begin
      add_byte({mk, LEN_EXT16});
      add_byte(8'(len >> 8));
      add_byte(8'(len));
    end else begin
      add_byte({mk, 7'(len)});
    end
    if (mk) repeat (4) add_byte(8'($urandom));
    repeat (len) add_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every call counts; printing stops after a while so a
  // badly broken block does not flood the log.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("tb: result %0d, %s: got 0x%0h, expected 0x%0h", results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. It drives at the falling edge and reads the transfer flag
  // captured at the previous rising edge. A presented byte stays put until its
  // transfer; after that the sender may wait a drawn number of cycles.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_item_t nxt;
    logic     v;
    v = in_valid;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!in_valid || in_taken) begin
      v = 1'b0;
      if (snd_gap != 0) begin
        snd_gap--;
      end else if (rx_stream.size() != 0 &&
                   !(rx_stream[0].drain && results_due.size() != 0)) begin
        nxt = rx_stream.pop_front();
        in_rx_byte <= nxt.b;
        v = 1'b1;
        if ($urandom_range(0, 31) == 0) snd_burst = ($urandom_range(0, 2) == 0);
        snd_gap = snd_burst ? 0 : $urandom_range(0, 9);
      end
    end
    in_valid <= v;
  end

  // ---------------------------------------------------------------------------
  // Result receiver. After each result transfer it draws how long to hold off.
  // Once in the run it holds off for a long stretch while the sender keeps
  // offering bytes, so the block fills up and has to drop in_ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic r;
    r = 1'b0;
    if (rst_n) begin
      if (out_taken) begin
        if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
          rcv_gap = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          if ($urandom_range(0, 31) == 0) rcv_burst = ($urandom_range(0, 2) == 0);
          rcv_gap = rcv_burst ? 0 : $urandom_range(0, 9);
        end
      end
      if (rcv_gap != 0) begin
        rcv_gap--;
      end else begin
        r = 1'b1;
      end
    end
    out_ready <= r;
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge an input transfer feeds the prediction first,
  // then an output transfer is checked against the oldest expected result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing expected, byte", out_byte, 0);
        end else begin
          want = results_due.pop_front();
          if (out_byte !== want.b) report_mismatch("byte", out_byte, want.b);
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_frame_opcode !== want.opc)
            report_mismatch("opcode", out_frame_opcode, want.opc);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the whole byte stream, release reset, wait for the
  // stream to drain and the results to arrive, then give the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0]  opc;
    logic        mk;
    logic        drain_placed;
    int unsigned len;
    int unsigned pick;
    int unsigned ending;
    drain_placed = 1'b0;

    for (int i = OPENING_LEN - 1; i >= 0; i--) add_byte(OPENING[i*8 +: 8]);

    // Random frames of every opcode except close. The parser has no error path
    // besides the two that end it, so every frame here is well formed; variety
    // comes from the header bits, the length forms, masking and content.
    while (rx_stream.size() < ITEM_TARGET + OPENING_LEN) begin
      // Somewhere in the middle the sender waits until all results are in.
      if (!drain_placed && rx_stream.size() >= 220) begin
        hold_next = 1'b1;
        drain_placed = 1'b1;
      end
      do opc = 4'($urandom); while (opc == OPC_CLOSE);
      mk = 1'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       add_frame(opc, mk, 0, 1'($urandom));
        6, 7:    add_frame(opc, mk, $urandom_range(9, 40), 1'b0);
        8:       add_frame(opc, mk, $urandom_range(0, 300), 1'b1);
        9:       add_frame(opc, mk, $urandom_range(100, 125), 1'b0);
        default: add_frame(opc, mk, $urandom_range(1, 8), 1'b0);
      endcase
    end

    // Only one way out of the parser can be taken per run, since reset comes
    // once: a close frame with payload, an empty close frame, or the 64-bit
    // length form. The seed picks which. Everything sent afterwards must be
    // swallowed without a result.
    hold_next = 1'b1;
    ending = $urandom_range(0, 2);
    case (ending)
      0: add_frame(OPC_CLOSE, 1'($urandom), $urandom_range(1, 6), 1'b0);
      1: add_frame(OPC_CLOSE, 1'($urandom), 0, 1'($urandom));
      default: begin
        add_byte({4'($urandom), 4'($urandom)});
        add_byte({1'($urandom), LEN_EXT64});
      end
    endcase
    repeat (8) add_byte(8'($urandom));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (rx_stream.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    // Room for any stray result the block might still push out.
    repeat (20) @(posedge clk);

    if (errors == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/wsfr_pkg.sv
hdl/wsfr_parser.sv
hdl/wsfr_out_stage.sv
hdl/websocket_frame_receiver.sv
bench/websocket_frame_receiver_tb.sv
